// File: sv/bvv_pkg.sv
// ----------------------------------------------------------------------------
// bvv_pkg
// Shared types and constants for the bounding volume block: the vertex and
// result structures and the bounds record passed from the front to the back.
// ----------------------------------------------------------------------------
package bvv_pkg;

    localparam int FIELD_W        = 32;
    localparam int COORD_BITS_DEF = 32;
    localparam int NUM_AXES       = 3;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic signed [FIELD_W-1:0] coord_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] vertex_x;
        logic signed [FIELD_W-1:0] vertex_y;
        logic signed [FIELD_W-1:0] vertex_z;
        logic                      last_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] box_min_x;
        logic signed [FIELD_W-1:0] box_min_y;
        logic signed [FIELD_W-1:0] box_min_z;
        logic signed [FIELD_W-1:0] box_max_x;
        logic signed [FIELD_W-1:0] box_max_y;
        logic signed [FIELD_W-1:0] box_max_z;
        logic signed [FIELD_W-1:0] center_x;
        logic signed [FIELD_W-1:0] center_y;
        logic signed [FIELD_W-1:0] center_z;
        logic        [FIELD_W-1:0] sphere_radius;
    } result_t;

    // Final bounds of one model, sign-extended to the field width.
    typedef struct packed {
        coord_t [NUM_AXES-1:0] lo;
        coord_t [NUM_AXES-1:0] hi;
    } bounds_t;

endpackage

// File: sv/bvv_front.sv
// ----------------------------------------------------------------------------
// bvv_front
// Accepts vertices, folds them into the running per-axis bounds and pushes
// the finished bounds of a model into the queue on the last vertex.
// ----------------------------------------------------------------------------
module bvv_front #(
    parameter int COORD_BITS = bvv_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vertex_valid,
    output logic             vertex_stall,
    input  bvv_pkg::vertex_t vertex,
    input  logic             queue_full,
    output logic             push,
    output bvv_pkg::bounds_t push_data
);
    import bvv_pkg::*;

    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] min_reg [NUM_AXES];
    logic signed [COORD_BITS-1:0] max_reg [NUM_AXES];
    logic signed [COORD_BITS-1:0] min_next[NUM_AXES];
    logic signed [COORD_BITS-1:0] max_next[NUM_AXES];
    logic signed [COORD_BITS-1:0] coord   [NUM_AXES];
    logic signed [COORD_BITS-1:0] new_min [NUM_AXES];
    logic signed [COORD_BITS-1:0] new_max [NUM_AXES];
    logic                         accept;

    // Only the last vertex of a model needs queue space, but stalling on a
    // full queue keeps the stall free of the payload.
    assign vertex_stall = queue_full;
    assign accept       = vertex_valid && !vertex_stall;
    assign push         = accept && vertex.last_vertex;

    always_comb
    begin
        coord[0] = vertex.vertex_x[COORD_BITS-1:0];
        coord[1] = vertex.vertex_y[COORD_BITS-1:0];
        coord[2] = vertex.vertex_z[COORD_BITS-1:0];
        for (int a = 0; a < NUM_AXES; a++)
        begin
            new_min[a] = (coord[a] < min_reg[a]) ? coord[a] : min_reg[a];
            new_max[a] = (coord[a] > max_reg[a]) ? coord[a] : max_reg[a];
            push_data.lo[a] = FIELD_W'(new_min[a]);
            push_data.hi[a] = FIELD_W'(new_max[a]);
            min_next[a] = min_reg[a];
            max_next[a] = max_reg[a];
            if (accept)
            begin
                min_next[a] = vertex.last_vertex ? C_MAX : new_min[a];
                max_next[a] = vertex.last_vertex ? C_MIN : new_max[a];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                min_reg[a] <= C_MAX;
                max_reg[a] <= C_MIN;
            end
        end
        else
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                min_reg[a] <= min_next[a];
                max_reg[a] <= max_next[a];
            end
        end
    end

endmodule

// File: sv/bvv_queue.sv
// ----------------------------------------------------------------------------
// bvv_queue
// Short first-in first-out queue of finished model bounds between the
// front and the back.
// ----------------------------------------------------------------------------
module bvv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bvv_pkg::bounds_t push_data,
    input  logic             pop,
    output bvv_pkg::bounds_t pop_data,
    output logic             full,
    output logic             empty
);
    import bvv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    bounds_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/bvv_back.sv
// ----------------------------------------------------------------------------
// bvv_back
// Takes one model's bounds from the queue, squares and sums the half
// extents, runs a bit-per-cycle square root and holds the result until
// the receiver takes it.
// ----------------------------------------------------------------------------
module bvv_back #(
    parameter int COORD_BITS = bvv_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  bvv_pkg::bounds_t pop_data,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output bvv_pkg::result_t result
);
    import bvv_pkg::*;

    localparam int HALF_W = COORD_BITS - 1;
    localparam int SQ_W   = 2 * HALF_W;
    localparam int SUM_W  = 2 * COORD_BITS;
    localparam int ITER_W = $clog2(COORD_BITS);
    localparam int STEP_W = $clog2(NUM_AXES + 1);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(COORD_BITS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_AXES);
    localparam logic [SUM_W-1:0]  BIT_INIT  = {2'b01, {(SUM_W-2){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_HOLD
    } state_t;

    state_t state_reg;
    logic   valid_reg;

    logic signed [COORD_BITS-1:0] lo_reg   [NUM_AXES];
    logic signed [COORD_BITS-1:0] hi_reg   [NUM_AXES];
    logic        [HALF_W-1:0]     half_reg [NUM_AXES];
    logic        [STEP_W-1:0]     step_reg;
    logic        [ITER_W-1:0]     iter_reg;
    logic        [SQ_W-1:0]       prod_reg;
    logic        [SUM_W-1:0]      acc_reg;
    logic        [SUM_W-1:0]      rem_reg;
    logic        [SUM_W-1:0]      root_reg;
    logic        [SUM_W-1:0]      bit_reg;
    result_t                      result_reg;

    logic signed [COORD_BITS-1:0] lo_in    [NUM_AXES];
    logic signed [COORD_BITS-1:0] hi_in    [NUM_AXES];
    logic        [COORD_BITS:0]   diff_in  [NUM_AXES];
    logic        [COORD_BITS:0]   ctr_wide [NUM_AXES];
    logic signed [COORD_BITS-1:0] center   [NUM_AXES];
    logic        [HALF_W-1:0]     half_sel;
    logic        [SQ_W-1:0]       prod;
    logic        [SUM_W-1:0]      acc_sum;
    logic        [SUM_W:0]        trial;
    logic                         take;
    logic        [SUM_W-1:0]      root_next;
    logic        [SUM_W-1:0]      rem_next;

    assign pop          = (state_reg == ST_IDLE) && !queue_empty;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lo_in[a]   = pop_data.lo[a][COORD_BITS-1:0];
            hi_in[a]   = pop_data.hi[a][COORD_BITS-1:0];
            diff_in[a] = {hi_in[a][COORD_BITS-1], hi_in[a]}
                       - {lo_in[a][COORD_BITS-1], lo_in[a]};
            // The center lies between min and max, so it fits the coordinate width.
            ctr_wide[a] = {hi_reg[a][COORD_BITS-1], hi_reg[a]} - {2'b00, half_reg[a]};
            center[a]   = ctr_wide[a][COORD_BITS-1:0];
        end
        half_sel  = (step_reg < LAST_STEP) ? half_reg[step_reg[STEP_W-1:0]] : '0;
        prod      = half_sel * half_sel;
        acc_sum   = acc_reg + SUM_W'(prod_reg);
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        take      = ({1'b0, rem_reg} >= trial);
        root_next = take ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
        rem_next  = take ? (rem_reg - trial[SUM_W-1:0]) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (iter_reg == LAST_ITER)
                    begin
                        state_reg <= ST_HOLD;
                        valid_reg <= 1'b1;
                    end
                end
                ST_HOLD:
                begin
                    if (!result_stall)
                    begin
                        state_reg <= ST_IDLE;
                        valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                lo_reg[a]   <= lo_in[a];
                hi_reg[a]   <= hi_in[a];
                half_reg[a] <= diff_in[a][COORD_BITS-1:1];
            end
            step_reg <= '0;
            acc_reg  <= '0;
        end
        if (state_reg == ST_SQUARE)
        begin
            // One product per cycle; the product is registered and summed in the next cycle.
            prod_reg <= prod;
            step_reg <= step_reg + 1'b1;
            if (step_reg != '0)
            begin
                acc_reg <= acc_sum;
            end
            if (step_reg == LAST_STEP)
            begin
                rem_reg  <= acc_sum;
                root_reg <= '0;
                bit_reg  <= BIT_INIT;
                iter_reg <= '0;
            end
        end
        if (state_reg == ST_ROOT)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            bit_reg  <= bit_reg >> 2;
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == LAST_ITER)
            begin
                result_reg.box_min_x     <= FIELD_W'(lo_reg[0]);
                result_reg.box_min_y     <= FIELD_W'(lo_reg[1]);
                result_reg.box_min_z     <= FIELD_W'(lo_reg[2]);
                result_reg.box_max_x     <= FIELD_W'(hi_reg[0]);
                result_reg.box_max_y     <= FIELD_W'(hi_reg[1]);
                result_reg.box_max_z     <= FIELD_W'(hi_reg[2]);
                result_reg.center_x      <= FIELD_W'(center[0]);
                result_reg.center_y      <= FIELD_W'(center[1]);
                result_reg.center_z      <= FIELD_W'(center[2]);
                result_reg.sphere_radius <= FIELD_W'(root_next[COORD_BITS-1:0]);
            end
        end
    end

endmodule

// File: sv/bounding_volume_from_vertices.sv
// ----------------------------------------------------------------------------
// bounding_volume_from_vertices
// Axis-aligned bounding box and bounding sphere of a vertex stream.
// ----------------------------------------------------------------------------
// Usage. Vertices arrive on the vertex channel (vertex_valid, vertex_stall,
// vertex), one request per model vertex, with last_vertex marking the final
// vertex of a model. Coordinates are signed Q16.16; only the low COORD_BITS
// bits are used. For each model one request leaves on the result channel
// (result_valid, result_stall, result) carrying the box minimum and maximum,
// the box center and the floored bounding sphere radius.
//
// Throughput. The front folds one vertex per cycle into the running bounds
// while the queue is not full. The back handles one model at a time: it
// takes the bounds from the queue, forms the three squares and their sum,
// and runs the bit-per-cycle square root loop, which sets the pace of the
// back. The two-entry queue holds finished models, so vertices keep flowing
// while the back works; vertex_stall rises only when both entries are taken,
// which happens when models end faster than the back finishes them or while
// result_stall holds a result.
//
// Reset clears the running bounds, the queue and the result channel. While
// the receiver stalls, the result request is held unchanged.
// ----------------------------------------------------------------------------
module bounding_volume_from_vertices #(
    parameter int COORD_BITS = bvv_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vertex_valid,
    output logic             vertex_stall,
    input  bvv_pkg::vertex_t vertex,
    output logic             result_valid,
    input  logic             result_stall,
    output bvv_pkg::result_t result
);
    import bvv_pkg::*;

    // Bounds of finished models travel from the front through the queue.
    logic    push;
    bounds_t push_data;
    logic    pop;
    bounds_t pop_data;
    logic    queue_full;
    logic    queue_empty;

    bvv_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .queue_full   (queue_full),
        .push         (push),
        .push_data    (push_data)
    );

    bvv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    bvv_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // A finished model is never pushed into a full queue.
    a_queue_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        push |-> !queue_full
    ) else $error("bounds pushed into a full queue");

    // The back never takes bounds from an empty queue.
    a_queue_no_underflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty
    ) else $error("bounds taken from an empty queue");

    // A delivered box is ordered on every axis.
    a_box_ordered: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(result.box_min_x) <= $signed(result.box_max_x)) &&
                         ($signed(result.box_min_y) <= $signed(result.box_max_y)) &&
                         ($signed(result.box_min_z) <= $signed(result.box_max_z))
    ) else $error("box minimum above box maximum");

    // The center lies inside the box on every axis.
    a_center_in_box: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(result.center_x) >= $signed(result.box_min_x)) &&
                         ($signed(result.center_x) <= $signed(result.box_max_x)) &&
                         ($signed(result.center_y) >= $signed(result.box_min_y)) &&
                         ($signed(result.center_y) <= $signed(result.box_max_y)) &&
                         ($signed(result.center_z) >= $signed(result.box_min_z)) &&
                         ($signed(result.center_z) <= $signed(result.box_max_z))
    ) else $error("center outside the box");

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounding_volume_from_vertices.
// Vertex models are streamed into the block, and each vertex is folded into
// a bounds predictor as it is accepted. Every request on the result channel
// is compared field by field against the oldest predicted result. Both
// channels see random idle and stall patterns. One long hold on the result
// side backs the block up until it stalls its vertex input.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bvv_pkg::*;

    localparam int     COORD_BITS   = COORD_BITS_DEF;
    localparam int     NUM_VERTICES = 1650;
    localparam int     CYCLE_LIMIT  = 1000000;
    // Covers the drain of the back after the last expected result.
    localparam int     DRAIN_CYCLES = 4 * (COORD_BITS + 6);
    localparam int     HOLD_CYCLES  = 600;
    localparam coord_t COORD_TOP    = 32'sh7fff_ffff;
    localparam coord_t COORD_BOTTOM = 32'sh8000_0000;

    // Ways of spreading the coordinates of one random model.
    typedef enum int {SPREAD_FULL, SPREAD_LOCAL, SPREAD_EDGES} spread_t;

    typedef logic [9:0][FIELD_W-1:0] result_words_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own running bounds, predicts one result per
    // model when the last vertex of the model is accepted, and checks the
    // results that the block delivers in order.
    // ------------------------------------------------------------------------
    class bounds_scoreboard;
        longint  run_lo [NUM_AXES];
        longint  run_hi [NUM_AXES];
        result_t expected_results [$];
        int      mismatches;
        int      failures;
        // Word 0 is the least significant field of the packed result.
        string   field_names [10] = '{"sphere_radius", "center_z", "center_y", "center_x",
                                      "box_max_z", "box_max_y", "box_max_x",
                                      "box_min_z", "box_min_y", "box_min_x"};

        function new();
            mismatches = 0;
            failures   = 0;
            clear_bounds();
        endfunction

        function void clear_bounds();
            for (int a = 0; a < NUM_AXES; a++)
            begin
                run_lo[a] = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
                run_hi[a] = -(64'sd1 <<< (COORD_BITS - 1));
            end
        endfunction

        function void note_vertex(vertex_t v);
            coord_t                       raw [NUM_AXES];
            logic signed [COORD_BITS-1:0] narrow;
            longint                       c;
            longint                       span;
            bit [63:0]                    half [NUM_AXES];
            bit [63:0]                    sum;
            bit [63:0]                    root;
            bit [63:0]                    cand;
            result_t                      r;

            raw = '{v.vertex_x, v.vertex_y, v.vertex_z};
            for (int a = 0; a < NUM_AXES; a++)
            begin
                // Only the low COORD_BITS bits count, taken as a signed value.
                narrow = raw[a][COORD_BITS-1:0];
                c = narrow;
                if (c < run_lo[a])
                    run_lo[a] = c;
                if (c > run_hi[a])
                    run_hi[a] = c;
            end
            if (!v.last_vertex)
                return;

            sum = 64'd0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                span    = run_hi[a] - run_lo[a];
                half[a] = 64'(span) >> 1;
                sum     = sum + half[a] * half[a];
            end
            // Floored square root, one result bit per step from the top.
            root = 64'd0;
            for (int b = FIELD_W - 1; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                if (cand * cand <= sum)
                    root = cand;
            end

            r.box_min_x     = run_lo[0][FIELD_W-1:0];
            r.box_min_y     = run_lo[1][FIELD_W-1:0];
            r.box_min_z     = run_lo[2][FIELD_W-1:0];
            r.box_max_x     = run_hi[0][FIELD_W-1:0];
            r.box_max_y     = run_hi[1][FIELD_W-1:0];
            r.box_max_z     = run_hi[2][FIELD_W-1:0];
            r.center_x      = 32'(run_hi[0] - longint'(half[0]));
            r.center_y      = 32'(run_hi[1] - longint'(half[1]));
            r.center_z      = 32'(run_hi[2] - longint'(half[2]));
            r.sphere_radius = root[FIELD_W-1:0];
            expected_results = {expected_results, r};
            clear_bounds();
        endfunction

        function void check_result(result_t got);
            result_t       want;
            result_words_t want_w;
            result_words_t got_w;

            if (expected_results.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result arrived with none expected: %h", $realtime, got);
                return;
            end
            want   = expected_results.pop_front();
            want_w = want;
            got_w  = got;
            if (got_w !== want_w)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    for (int i = 9; i >= 0; i--)
                    begin
                        if (got_w[i] !== want_w[i])
                            $display("%0t: %s expected %h, got %h", $realtime,
                                     field_names[i], want_w[i], got_w[i]);
                    end
                end
            end
        endfunction

        function void close_out();
            if (expected_results.size() != 0)
            begin
                failures += expected_results.size();
                $display("%0d expected results never arrived", expected_results.size());
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    vertex_valid;
    logic    vertex_stall;
    vertex_t vertex;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    bounds_scoreboard sb = new();
    int               vertices_sent = 0;
    bit               hold_results  = 1'b0;
    int               cycle_count   = 0;

    bounding_volume_from_vertices i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle and stall lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t pick_coord(spread_t spread, coord_t base);
        int pick;
        case (spread)
            SPREAD_FULL:
                return coord_t'($urandom);
            SPREAD_LOCAL:
                return base + coord_t'($urandom_range(0, 4000)) - 32'sd2000;
            default:
            begin
                // Values at and next to the ends of the coordinate range, and around zero.
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       return COORD_TOP;
                    1:       return COORD_BOTTOM;
                    2:       return COORD_TOP - 32'sd1;
                    3:       return COORD_BOTTOM + 32'sd1;
                    4:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic vertex_t make_vertex(coord_t x, coord_t y, coord_t z, bit last);
        vertex_t v;
        v.vertex_x    = x;
        v.vertex_y    = y;
        v.vertex_z    = z;
        v.last_vertex = last;
        return v;
    endfunction

    // Offers one vertex request after an optional idle gap and returns at the
    // edge where it is accepted. The caller is always at a rising edge, and
    // valid is only lowered when a gap follows, so it never toggles within a
    // single time step.
    task automatic send_vertex(input vertex_t v, input int gap);
        if (gap > 0)
        begin
            vertex_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vertex_valid <= 1'b1;
        vertex       <= v;
        // Signals read right after the edge still hold their pre-edge values.
        do
            @(posedge clk);
        while (vertex_stall);
        sb.note_vertex(v);
        vertices_sent++;
    endtask

    // One random model of len vertices; a steady model is sent back to back.
    task automatic send_model(input int len, input spread_t spread, input bit steady);
        vertex_t v;
        coord_t  base_x;
        coord_t  base_y;
        coord_t  base_z;

        base_x = coord_t'($urandom);
        base_y = coord_t'($urandom);
        base_z = coord_t'($urandom);
        for (int i = 0; i < len; i++)
        begin
            v = make_vertex(pick_coord(spread, base_x), pick_coord(spread, base_y),
                            pick_coord(spread, base_z), i == len - 1);
            send_vertex(v, steady ? 0 : pick_gap());
        end
    endtask

    // Main stimulus: reset, a directed set of models, then random models.
    initial
    begin
        int len;
        int r;

        rst_n        <= 1'b0;
        vertex_valid <= 1'b0;
        vertex       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-vertex models at zero and at both ends of the range. The box
        // collapses to a point, the center is the vertex and the radius is 0.
        send_vertex(make_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1), 0);
        send_vertex(make_vertex(COORD_TOP, COORD_TOP, COORD_TOP, 1'b1), 0);
        send_vertex(make_vertex(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b1), 1);
        // The full span on every axis gives the largest half extents and the
        // largest radius that can occur.
        send_vertex(make_vertex(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b0), 0);
        send_vertex(make_vertex(COORD_TOP, COORD_TOP, COORD_TOP, 1'b1), 0);
        // Mixed ends per axis, with the extremes reached in different vertices.
        send_vertex(make_vertex(COORD_TOP, COORD_BOTTOM, 32'sd0, 1'b0), 2);
        send_vertex(make_vertex(COORD_BOTTOM, COORD_TOP, -32'sd1, 1'b1), 0);
        // An odd extent on x, reaching down to a negative minimum, checks the flooring of the
        // half extent and the center that follows from it.
        send_vertex(make_vertex(32'sd1, -32'sd3, 32'sh0001_0000, 1'b0), 0);
        send_vertex(make_vertex(-32'sh0001_0000, 32'sd0, 32'sd3, 1'b0), 0);
        send_vertex(make_vertex(32'sd5, 32'sd5, 32'sh0001_8001, 1'b1), 0);
        // A model of repeated identical vertices.
        send_vertex(make_vertex(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ffff, 1'b0), 0);
        send_vertex(make_vertex(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ffff, 1'b0), 3);
        send_vertex(make_vertex(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ffff, 1'b1), 0);
        // Alternating bit patterns in every coordinate.
        send_vertex(make_vertex(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b0), 0);
        send_vertex(make_vertex(32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b1), 0);

        // Random models. Most are short so that results come often, a few
        // are long, and about one in four is sent without any idle cycles.
        while (vertices_sent < NUM_VERTICES)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 6);
            else if (r < 95)
                len = $urandom_range(7, 20);
            else
                len = $urandom_range(21, 60);
            send_model(len, spread_t'($urandom_range(0, 2)), $urandom_range(0, 3) == 0);
        end
        vertex_valid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Result side: checks each accepted result; result_stall alternates ready
    // runs, sometimes long, with stall gaps, and stays high under hold_results.
    initial
    begin
        int stall_left;
        int run_left;

        stall_left = 0;
        run_left   = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(result);
            if (stall_left == 0 && run_left == 0)
            begin
                run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                           : $urandom_range(1, 4);
                stall_left = pick_gap();
            end
            if (run_left > 0)
            begin
                run_left--;
                result_stall <= hold_results;
            end
            else
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
        end
    end

    // Long hold on the result side partway through the random models. The
    // vertex side keeps offering, so the queue fills and the block has to
    // stall its vertex input.
    initial
    begin
        wait (vertices_sent >= 600);
        @(posedge clk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb failed");
        $finish;
    end

endmodule

// File: bounding_volume_from_vertices.f
sv/bvv_pkg.sv
sv/bvv_front.sv
sv/bvv_queue.sv
sv/bvv_back.sv
sv/bounding_volume_from_vertices.sv
test/tb.sv
